// File: rtl/psxy_pkg.sv
package psxy_pkg;

   // Width of the coordinate fields on the ports.
   localparam int FIELD_BITS = 11;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RD,
      ST_CMP,
      ST_PUT,
      ST_OUT
   } psxy_state_type;

   // Handshake and result flags from the sequencer to the top level.
   typedef struct packed {
      logic busy;
      logic valid;
      logic last;
      logic ovf;
   } psxy_status_type;

endpackage

// File: rtl/psxy_store.sv
module psxy_store import psxy_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 22
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/psxy_ctrl.sv
module psxy_ctrl import psxy_pkg::*; #(
   parameter int DEPTH    = 64,
   parameter int KEY_BITS = 22
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [KEY_BITS-1:0]      key_req,
   input  logic                     req_last,
   input  logic [KEY_BITS-1:0]      mem_rdata,
   output logic                     mem_we,
   output logic [$clog2(DEPTH)-1:0] mem_waddr,
   output logic [KEY_BITS-1:0]      mem_wdata,
   output logic [$clog2(DEPTH)-1:0] mem_raddr,
   output psxy_status_type          status
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int AW    = $clog2(DEPTH);

   psxy_state_type      state_ff, state_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                is_last_ff, is_last_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                ovf_ff, ovf_in;
   logic                pend_ff, pend_in;
   logic                pend_last_ff, pend_last_in;
   logic                pend_ovf_ff, pend_ovf_in;

   logic             accept;
   logic             full;
   logic             greater;
   logic             out_end;
   logic [CNT_W-1:0] pos_m1;

   assign accept  = start && (state_ff == ST_IDLE);
   assign full    = (count_ff == CNT_W'(DEPTH));
   assign greater = (mem_rdata > key_ff);
   assign pos_m1  = pos_ff - 1'b1;
   assign out_end = (pos_ff == (count_ff - 1'b1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (full) begin
                  state_in = req_last ? ST_OUT : ST_IDLE;
               end else if (count_ff == '0) begin
                  state_in = ST_PUT;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (greater) begin
               state_in = (pos_ff == CNT_W'(1)) ? ST_PUT : ST_RD;
            end else begin
               state_in = is_last_ff ? ST_OUT : ST_IDLE;
            end
         end
         ST_PUT: begin
            state_in = is_last_ff ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            state_in = out_end ? ST_IDLE : ST_OUT;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      key_in       = key_ff;
      is_last_in   = is_last_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      pend_in      = 1'b0;
      pend_last_in = 1'b0;
      pend_ovf_in  = ovf_ff;
      mem_we       = 1'b0;
      mem_waddr    = pos_ff[AW-1:0];
      mem_wdata    = key_ff;
      mem_raddr    = pos_m1[AW-1:0];
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               key_in     = key_req;
               is_last_in = req_last;
               if (full) begin
                  ovf_in = 1'b1;
                  pos_in = '0;
               end else begin
                  pos_in = count_ff;
               end
            end
         end
         ST_RD: begin
            mem_raddr = pos_m1[AW-1:0];
         end
         ST_CMP: begin
            mem_we = 1'b1;
            if (greater) begin
               // Move the larger neighbor up one slot and keep walking down.
               mem_wdata = mem_rdata;
               pos_in    = pos_m1;
            end else begin
               mem_wdata = key_ff;
               count_in  = count_ff + 1'b1;
               pos_in    = '0;
            end
         end
         ST_PUT: begin
            mem_we    = 1'b1;
            mem_wdata = key_ff;
            count_in  = count_ff + 1'b1;
            pos_in    = '0;
         end
         ST_OUT: begin
            mem_raddr    = pos_ff[AW-1:0];
            pend_in      = 1'b1;
            pend_last_in = out_end;
            pend_ovf_in  = ovf_ff;
            pos_in       = pos_ff + 1'b1;
            if (out_end) begin
               count_in = '0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            pos_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         pend_ff  <= pend_in;
      end
      key_ff       <= key_in;
      is_last_ff   <= is_last_in;
      pos_ff       <= pos_in;
      pend_last_ff <= pend_last_in;
      pend_ovf_ff  <= pend_ovf_in;
   end

   assign status.busy  = (state_ff != ST_IDLE);
   assign status.valid = pend_ff;
   assign status.last  = pend_last_ff;
   assign status.ovf   = pend_ovf_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("point count exceeds store depth");

   a_write_states: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == ST_CMP || state_ff == ST_PUT))
      else $error("store written outside insertion");

   a_result_from_scan: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(state_ff == ST_OUT))
      else $error("result strobe without an output read");

   a_set_cleared: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && pend_last_ff) |-> (count_ff == '0 && !ovf_ff && state_ff == ST_IDLE))
      else $error("set not cleared after its final result");

endmodule

// File: rtl/point_sort_xy_core.sv
// Lexicographic point sorter.
// Points arrive one item at a time on req_point_x / req_point_y; an item is
// taken at a rising edge where start is high and busy is low. Each point is
// placed into a sorted store by insertion: a single key comparator walks down
// the stored points, each step a store read followed by a compare, shifting
// larger points up one slot until the new point's place is found. Inserting
// into an empty store writes the point directly; busy is high throughout an
// insertion. A point that finds the store full is dropped at once and busy
// stays low, unless that point closes the set.
// An item with req_is_last set closes the set. After its insertion the store
// is read out in ascending order of x, then y, one point per cycle; each
// result appears in the cycle after its store read because the read is
// registered. A set of n points therefore streams out as n back-to-back
// results with rsp_valid high, rsp_last_out high on the final one.
// Points beyond DEPTH are dropped and rsp_overflow is reported on every result
// of that set. Count and overflow return to zero once the set has been sent.
// The receiver cannot stall: each result is present for exactly one cycle.
// Synchronous reset empties the store logically (count zero) and idles the
// sequencer; no clearing pass is needed since only written entries are read.
module point_sort_xy_core import psxy_pkg::*; #(
   parameter int DEPTH      = 64,
   parameter int COORD_BITS = 11
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [FIELD_BITS-1:0] req_point_x,
   input  logic [FIELD_BITS-1:0] req_point_y,
   input  logic                  req_is_last,
   output logic                  rsp_valid,
   output logic [FIELD_BITS-1:0] rsp_sorted_x,
   output logic [FIELD_BITS-1:0] rsp_sorted_y,
   output logic                  rsp_last_out,
   output logic                  rsp_overflow
);

   localparam int KEY_BITS = 2 * COORD_BITS;
   localparam int AW       = $clog2(DEPTH);

   // The sort key packs x above y so one unsigned compare orders by x, then y.
   logic [KEY_BITS-1:0] key_req;
   logic [KEY_BITS-1:0] mem_rdata;
   logic [KEY_BITS-1:0] mem_wdata;
   logic [AW-1:0]       mem_waddr;
   logic [AW-1:0]       mem_raddr;
   logic                mem_we;
   psxy_status_type     status;

   assign key_req = {COORD_BITS'(req_point_x), COORD_BITS'(req_point_y)};

   psxy_ctrl #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .key_req   (key_req),
      .req_last  (req_is_last),
      .mem_rdata (mem_rdata),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_raddr (mem_raddr),
      .status    (status)
   );

   psxy_store #(
      .DEPTH (DEPTH),
      .WIDTH (KEY_BITS)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Results come straight from the registered store read.
   assign busy         = status.busy;
   assign rsp_valid    = status.valid;
   assign rsp_last_out = status.last;
   assign rsp_overflow = status.ovf;
   assign rsp_sorted_x = FIELD_BITS'(mem_rdata[KEY_BITS-1:COORD_BITS]);
   assign rsp_sorted_y = FIELD_BITS'(mem_rdata[COORD_BITS-1:0]);

endmodule
